/* hw/rtl/kbm_pkg.sv */
package kbm_pkg;

	localparam int PATTERN_COUNT = 37;
	localparam int WINDOW_BYTES  = 24;
	localparam int HIST_DEPTH    = WINDOW_BYTES - 1;
	localparam int MAX_CHARS     = 8;
	localparam int CHAR_BYTES    = 3;

	typedef logic [7:0] byte_t;
	typedef logic [15:0] cp_t;
	typedef logic [3:0] nchars_t;
	typedef byte_t hist_t [HIST_DEPTH];

	typedef struct packed {
		logic shift;
		logic clear;
		logic hit;
	} hist_ctrl_t;

	localparam nchars_t PAT_CHARS [PATTERN_COUNT] = '{
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd2, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2,
		4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2,
		4'd2, 4'd2, 4'd2, 4'd1, 4'd2, 4'd3, 4'd8, 4'd4,
		4'd2, 4'd2, 4'd2, 4'd2, 4'd4
	};

	localparam cp_t PAT_CP [PATTERN_COUNT][MAX_CHARS] = '{
		'{16'h6740, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h6B7B, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h8840, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h5200, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h67AA, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h6253, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h63CD, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h6740, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h5C38, 16'h4F53, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h81EA, 16'h6740, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h6253, 16'h67B6, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h6027, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h505A, 16'h7231, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h8272, 16'h60C5, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h88F8, 16'h4F53, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h5E8A, 16'h620F, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h8131, 16'h8863, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h653F, 16'h6CBB, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h653F, 16'h5E9C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h5171, 16'h4EA7, 16'h515A, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h56FD, 16'h6C11, 16'h515A, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h53F0, 16'h72EC, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h6E2F, 16'h72EC, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h85CF, 16'h72EC, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h5B97, 16'h6559, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h8036, 16'h7A23, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h771F, 16'h4E3B, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h4F5B, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h4E0A, 16'h5E1D, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h6211, 16'h7231, 16'h4F60, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h4F60, 16'h662F, 16'h6211, 16'h6700, 16'h597D, 16'h7684, 16'h670B,
			16'h53CB},
		'{16'h79BB, 16'h4E0D, 16'h5F00, 16'h4F60, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h6BD2, 16'h54C1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h8D4C, 16'h535A, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h62BD, 16'h70DF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h559D, 16'h9152, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{16'h81EA, 16'h6740, 16'h65B9, 16'h6CD5, 16'h0, 16'h0, 16'h0, 16'h0}
	};

	// Byte sb of the three-byte UTF-8 form of code point cp.
	function automatic byte_t utf8_byte(input cp_t cp, input logic [1:0] sb);
		byte_t b;
		case (sb)
			2'd0: begin
				b = {4'hE, cp[15:12]};
			end
			2'd1: begin
				b = {2'b10, cp[11:6]};
			end
			default: begin
				b = {2'b10, cp[5:0]};
			end
		endcase
		return b;
	endfunction

endpackage

/* hw/rtl/kbm_match.sv */
module kbm_match (
	input  kbm_pkg::byte_t cur_byte,
	input  kbm_pkg::hist_t hist,
	output logic           hit
);

	kbm_pkg::byte_t win [kbm_pkg::WINDOW_BYTES];

	always_comb begin
		win[0] = cur_byte;
		for (int k = 1; k < kbm_pkg::WINDOW_BYTES; k++) begin
			win[k] = hist[k - 1];
		end
	end

	// Each pattern is checked against the window that ends at the current byte.
	always_comb begin
		logic ok;
		int   len;
		int   j;
		hit = 1'b0;
		for (int p = 0; p < kbm_pkg::PATTERN_COUNT; p++) begin
			len = kbm_pkg::CHAR_BYTES * int'(kbm_pkg::PAT_CHARS[p]);
			ok  = (kbm_pkg::PAT_CHARS[p] != 4'd0) &&
				(int'(kbm_pkg::PAT_CHARS[p]) <= kbm_pkg::MAX_CHARS) &&
				(len <= kbm_pkg::WINDOW_BYTES);
			for (int ci = 0; ci < kbm_pkg::MAX_CHARS; ci++) begin
				for (int sb = 0; sb < kbm_pkg::CHAR_BYTES; sb++) begin
					j = len - 1 - (kbm_pkg::CHAR_BYTES * ci + sb);
					if (ok && (j >= 0) && (j < kbm_pkg::WINDOW_BYTES)) begin
						if (win[j] != kbm_pkg::utf8_byte(kbm_pkg::PAT_CP[p][ci],
								2'(sb))) begin
							ok = 1'b0;
						end
					end
				end
			end
			hit = hit | ok;
		end
	end

endmodule

/* hw/rtl/kbm_history.sv */
module kbm_history (
	input  logic                clk,
	input  logic                arst_n,
	input  kbm_pkg::hist_ctrl_t ctrl,
	input  kbm_pkg::byte_t      new_byte,
	output kbm_pkg::hist_t      hist,
	output logic                hit_seen
);

	kbm_pkg::hist_t hist_q;
	logic           hit_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < kbm_pkg::HIST_DEPTH; k++) begin
				hist_q[k] <= '0;
			end
			hit_seen_q <= 1'b0;
		end else if (ctrl.clear) begin
			for (int k = 0; k < kbm_pkg::HIST_DEPTH; k++) begin
				hist_q[k] <= '0;
			end
			hit_seen_q <= 1'b0;
		end else begin
			if (ctrl.shift) begin
				hist_q[0] <= new_byte;
				for (int k = 1; k < kbm_pkg::HIST_DEPTH; k++) begin
					hist_q[k] <= hist_q[k - 1];
				end
			end
			if (ctrl.hit) begin
				hit_seen_q <= 1'b1;
			end
		end
	end

	assign hist     = hist_q;
	assign hit_seen = hit_seen_q;

endmodule

/* hw/rtl/keyword_blocklist_matcher_top.sv */
// Blocked-string matcher for UTF-8 text streams.
// The input channel (in_valid, in_stall) carries one item per text byte:
// has_byte marks a real byte in text_byte, last marks the final item of a
// text. An item with has_byte low and last high ends the text without a
// byte; with last also low it is dropped. A text with no bytes is safe.
// The output channel (out_valid, out_stall) carries one item per text,
// text_safe, which is low when any blocked string occurred in the text.
// An accepted item sits in an input register, where it is compared against
// all patterns at once over it and the 23 preceding bytes, and the verdict
// is written to the output register. The result of a last item is offered
// once that item leaves the input register. One item is accepted every
// cycle unless the input stalls; the rate is set by the single compare stage.
// Reset clears the byte history, the hit flag and both valid registers.
// While the output item is stalled, items that are not last keep flowing;
// a last item waits in the input register and the input stalls until the
// pending result is taken.
module keyword_blocklist_matcher_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       has_byte,
	input  logic [7:0] text_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       text_safe
);

	logic                valid_s1;
	logic                has_s1;
	logic                last_s1;
	kbm_pkg::byte_t      byte_s1;
	logic                adv_s1;
	logic                match_hit;
	logic                hit_seen;
	kbm_pkg::hist_t      hist;
	kbm_pkg::hist_ctrl_t hctrl;
	logic                out_valid_q;
	logic                text_safe_q;

	assign adv_s1   = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			has_s1  <= has_byte;
			last_s1 <= last;
			byte_s1 <= text_byte;
		end
	end

	kbm_match u_match (
		.cur_byte (byte_s1),
		.hist     (hist),
		.hit      (match_hit)
	);

	assign hctrl.shift = adv_s1 && has_s1;
	assign hctrl.clear = adv_s1 && last_s1;
	assign hctrl.hit   = adv_s1 && has_s1 && match_hit;

	kbm_history u_history (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (hctrl),
		.new_byte (byte_s1),
		.hist     (hist),
		.hit_seen (hit_seen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			text_safe_q <= !(hit_seen || (has_s1 && match_hit));
		end
	end

	assign out_valid = out_valid_q;
	assign text_safe = text_safe_q;

	a_stall_only_on_pending_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a pending result");

	a_flag_clear_after_text: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> !hit_seen)
		else $error("hit flag survived the end of a text");

	a_hit_gives_unsafe: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1 && hit_seen) |=> (out_valid && !text_safe))
		else $error("text with a hit not reported as unsafe");

	a_hit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_seen && !(adv_s1 && last_s1)) |=> hit_seen)
		else $error("hit flag dropped within a text");

endmodule

/* tb/tb_keyword_blocklist_matcher_top.sv */
`timescale 1ns / 100ps

module tb_keyword_blocklist_matcher_top;

	localparam int NUM_PATTERNS = 37;
	localparam int NUM_CODES = 77;
	localparam int WINDOW = 24;
	localparam int RANDOM_BYTES = 1425;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_LIMIT = 10;
	localparam int LONG_PATTERN = 30;

	localparam int BLK_NCHARS [NUM_PATTERNS] = '{
		1, 1, 1, 1, 1, 1, 1, 1, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 2,
		3, 3, 2, 2, 2, 2, 2, 2, 1, 2, 3, 8, 4, 2, 2, 2, 2, 4
	};

	localparam logic [15:0] BLK_CODES [NUM_CODES] = '{
		16'h6740, 16'h6B7B, 16'h8840, 16'h5200, 16'h67AA, 16'h6253, 16'h63CD, 16'h6740,
		16'h5C38, 16'h4F53, 16'h81EA, 16'h6740, 16'h6253, 16'h67B6, 16'h6027,
		16'h505A, 16'h7231, 16'h8272, 16'h60C5, 16'h88F8, 16'h4F53, 16'h5E8A, 16'h620F,
		16'h8131, 16'h8863, 16'h653F, 16'h6CBB, 16'h653F, 16'h5E9C,
		16'h5171, 16'h4EA7, 16'h515A, 16'h56FD, 16'h6C11, 16'h515A,
		16'h53F0, 16'h72EC, 16'h6E2F, 16'h72EC, 16'h85CF, 16'h72EC, 16'h5B97, 16'h6559,
		16'h8036, 16'h7A23, 16'h771F, 16'h4E3B, 16'h4F5B, 16'h4E0A, 16'h5E1D,
		16'h6211, 16'h7231, 16'h4F60,
		16'h4F60, 16'h662F, 16'h6211, 16'h6700, 16'h597D, 16'h7684, 16'h670B, 16'h53CB,
		16'h79BB, 16'h4E0D, 16'h5F00, 16'h4F60,
		16'h6BD2, 16'h54C1, 16'h8D4C, 16'h535A, 16'h62BD, 16'h70DF, 16'h559D, 16'h9152,
		16'h81EA, 16'h6740, 16'h65B9, 16'h6CD5
	};

	typedef struct packed {
		logic       has_byte;
		logic [7:0] text_byte;
		logic       last;
		logic       fixed_exp;
		logic       fixed_safe;
	} text_item_t;

	// Where fixed_exp is set, the verdict of the text is given by fixed_safe.
	localparam text_item_t DIRECTED [24] = '{
		'{1'b0, 8'h00, 1'b1, 1'b1, 1'b1},
		'{1'b0, 8'h01, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h01, 1'b0, 1'b0, 1'b0},
		'{1'b0, 8'hFF, 1'b1, 1'b1, 1'b1},
		'{1'b1, 8'hE6, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h9D, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h80, 1'b1, 1'b1, 1'b0},
		'{1'b1, 8'hE6, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h9D, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h80, 1'b1, 1'b1, 1'b1},
		'{1'b1, 8'hE6, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h9D, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h80, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h41, 1'b0, 1'b0, 1'b0},
		'{1'b0, 8'h00, 1'b1, 1'b1, 1'b0},
		'{1'b1, 8'hE6, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h94, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'hBF, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'hE6, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'hB2, 1'b0, 1'b0, 1'b0},
		'{1'b1, 8'hBB, 1'b1, 1'b0, 1'b0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       has_byte;
	logic [7:0] text_byte;
	logic       last;
	logic       out_valid;
	logic       out_stall;
	logic       text_safe;

	logic [7:0] pat_bytes [NUM_PATTERNS][WINDOW];
	int         pat_len [NUM_PATTERNS];
	logic [7:0] recent [WINDOW-1];
	logic       hit_seen;
	text_item_t stim_q [$];
	logic       safe_expect_q [$];
	text_item_t cur_item;
	int         n_accepted = 0;
	int         n_bytes = 0;
	int         n_errors = 0;
	int         cycle_count = 0;
	wire        steady = (n_accepted >= 800) && (n_accepted < 1100);

	keyword_blocklist_matcher_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.has_byte  (has_byte),
		.text_byte (text_byte),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_safe (text_safe)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		n_errors++;
		if (n_errors <= REPORT_LIMIT) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	task automatic load_blocklist();
		int off;
		logic [15:0] cp;
		off = 0;
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			pat_len[p] = 3 * BLK_NCHARS[p];
			for (int c = 0; c < BLK_NCHARS[p]; c++) begin
				cp = BLK_CODES[off + c];
				pat_bytes[p][3*c]   = {4'hE, cp[15:12]};
				pat_bytes[p][3*c+1] = {2'b10, cp[11:6]};
				pat_bytes[p][3*c+2] = {2'b10, cp[5:0]};
			end
			off += BLK_NCHARS[p];
		end
	endtask

	task automatic clear_window();
		for (int i = 0; i < WINDOW - 1; i++) begin
			recent[i] = 8'h00;
		end
		hit_seen = 1'b0;
	endtask

	function automatic logic ends_with_pattern(input logic [7:0] cur);
		logic found;
		logic ok;
		logic [7:0] have;
		found = 1'b0;
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			if (pat_len[p] != 0 && pat_len[p] <= WINDOW) begin
				ok = 1'b1;
				for (int j = 0; j < pat_len[p]; j++) begin
					have = (j == 0) ? cur : recent[j-1];
					if (have != pat_bytes[p][pat_len[p] - 1 - j]) begin
						ok = 1'b0;
					end
				end
				found = found | ok;
			end
		end
		return found;
	endfunction

	task automatic track_text(input text_item_t it);
		if (it.has_byte) begin
			if (ends_with_pattern(it.text_byte)) begin
				hit_seen = 1'b1;
			end
			for (int i = WINDOW - 2; i > 0; i--) begin
				recent[i] = recent[i-1];
			end
			recent[0] = it.text_byte;
		end
		if (it.last) begin
			safe_expect_q.push_back(it.fixed_exp ? it.fixed_safe : !hit_seen);
			clear_window();
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		stim_q.push_back('{1'b1, b, 1'b0, 1'b0, 1'b0});
		n_bytes++;
	endtask

	task automatic add_text();
		int nseg;
		int kind;
		int p;
		int len;
		int cut;
		int flip;
		text_item_t tail;
		nseg = $urandom_range(0, 6);
		for (int s = 0; s < nseg; s++) begin
			kind = $urandom_range(0, 99);
			p = ($urandom_range(0, 3) == 0) ? LONG_PATTERN : $urandom_range(0, NUM_PATTERNS - 1);
			len = pat_len[p];
			if (kind < 22) begin
				for (int k = 0; k < len; k++) begin
					push_byte(pat_bytes[p][k]);
				end
			end else if (kind < 36) begin
				cut = $urandom_range(1, len - 1);
				for (int k = 0; k < cut; k++) begin
					push_byte(pat_bytes[p][k]);
				end
			end else if (kind < 46) begin
				cut = $urandom_range(1, len - 1);
				for (int k = cut; k < len; k++) begin
					push_byte(pat_bytes[p][k]);
				end
			end else if (kind < 56) begin
				flip = $urandom_range(0, len - 1);
				for (int k = 0; k < len; k++) begin
					if (k == flip) begin
						push_byte(pat_bytes[p][k] ^ (8'h01 << $urandom_range(0, 7)));
					end else begin
						push_byte(pat_bytes[p][k]);
					end
				end
			end else if (kind < 72) begin
				push_byte(8'($urandom_range(8'hE4, 8'hE9)));
				push_byte({2'b10, 6'($urandom)});
				push_byte({2'b10, 6'($urandom)});
			end else if (kind < 82) begin
				push_byte(8'($urandom_range(1, 127)));
			end else if (kind < 92) begin
				push_byte(8'($urandom_range(0, 255)));
			end else if (kind < 96) begin
				stim_q.push_back('{1'b0, 8'($urandom), 1'b0, 1'b0, 1'b0});
			end else begin
				push_byte(8'h00);
			end
		end
		tail = stim_q[stim_q.size() - 1];
		if (tail.has_byte && !tail.last && $urandom_range(0, 1) == 1) begin
			tail = stim_q.pop_back();
			tail.last = 1'b1;
			stim_q.push_back(tail);
		end else begin
			stim_q.push_back('{1'b0, 8'($urandom), 1'b1, 1'b0, 1'b0});
		end
	endtask

	initial begin : drive_items
		in_valid = 1'b0;
		has_byte = 1'b0;
		text_byte = 8'h00;
		last = 1'b0;
		load_blocklist();
		clear_window();
		foreach (DIRECTED[i]) begin
			stim_q.push_back(DIRECTED[i]);
		end
		n_bytes = 0;
		while (n_bytes < RANDOM_BYTES) begin
			add_text();
		end
		wait (arst_n === 1'b1);
		while (stim_q.size() != 0 || in_valid) begin
			@(posedge clk);
			if (in_valid && !in_stall) begin
				track_text(cur_item);
				n_accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (stim_q.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
					cur_item = stim_q.pop_front();
					in_valid <= 1'b1;
					has_byte <= cur_item.has_byte;
					text_byte <= cur_item.text_byte;
					last <= cur_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
		while (safe_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : take_results
		int hold_left;
		bit held;
		logic want;
		out_stall = 1'b0;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (safe_expect_q.size() == 0) begin
					report_error($sformatf("text_safe=%0b with no text pending", text_safe));
				end else begin
					want = safe_expect_q.pop_front();
					if (text_safe !== want) begin
						report_error($sformatf("text_safe expected %0b, got %0b", want,
							text_safe));
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!held && n_accepted >= 400) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < 15);
			end
		end
	end

endmodule
